[design/mvlo_pkg.sv]
// Package for the mask-value list orderer.
// Holds the request, response and internal operation types and fixed widths.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package mvlo_pkg;

   localparam int MASK_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int POS_W     = 5;
   localparam int OP_DEPTH  = 2;
   localparam int OUT_DEPTH = 4;

   typedef struct packed {
      logic [MASK_W-1:0]  item_mask;
      logic [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] slot_value;
      logic [MASK_W-1:0]  combined_mask;
      logic               is_last;
      logic               is_empty;
   } rsp_type;

   // A classified item as it travels from the front to the back.
   typedef struct packed {
      logic               is_term;
      logic [POS_W-1:0]   slot;
      logic [MASK_W-1:0]  mask;
      logic [VALUE_W-1:0] value;
   } op_type;

endpackage
`default_nettype wire

[design/mask_value_list_orderer_unit.sv]
// Top level of the mask-value list orderer.
// Instantiates mvlo_front and mvlo_back; depends on mvlo_pkg.
//
// A mask-value pair is taken every cycle while req_full is low: the front end
// picks the slot from the most significant mask bit and queues the pair in a
// two-entry operation queue, and the back end writes it to the slot store. An
// item with a zero mask closes the list; the back end then reads one filled
// slot per cycle while there is room, lowest first, through the registered
// read port of the slot store into a four-entry response queue, so a list of
// n filled slots yields n transfers at up to one per cycle, paced by rsp_pop,
// and an empty list yields a single transfer flagged empty. Items behind a
// terminator wait in the operation queue until every read of the burst has
// been issued. Slot valid bits clear at reset, so no clearing pass is needed.
`default_nettype none
module mask_value_list_orderer_unit
   import mvlo_pkg::*;
#(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_item,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_item
);

   logic   op_valid;
   op_type op_data;
   logic   op_take;

   // Classification and operation queue.
   mvlo_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_take  (op_take)
   );

   // Slot store, emission and response queue.
   mvlo_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_take   (op_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

[design/mvlo_front.sv]
// Front end of the mask-value list orderer: accepts items and classifies them.
// Finds the target slot of each pair and queues the operation for the back end.
// Depends on mvlo_pkg.
`default_nettype none
module mvlo_front
   import mvlo_pkg::*;
#(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_item,
   output logic         op_valid,
   output op_type       op_data,
   input  wire logic    op_take
);

   localparam int PTR_W = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
   localparam int CNT_W = $clog2(OP_DEPTH + 1);

   op_type             op_q_ff [OP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   top_pos;
   logic [POS_W-1:0]   slot_sel;
   op_type             new_op;
   logic               push_ok;
   logic               take_ok;

   // The most significant set bit of the mask picks the slot.
   always_comb begin
      top_pos = '0;
      for (int k = 0; k < MASK_W; k++) begin
         if (req_item.item_mask[k]) begin
            top_pos = POS_W'(k);
         end
      end
   end

   // Bits above the top slot fold into the top slot.
   always_comb begin
      if (top_pos > POS_W'(SLOT_COUNT - 1)) begin
         slot_sel = POS_W'(SLOT_COUNT - 1);
      end else begin
         slot_sel = top_pos;
      end
   end

   always_comb begin
      new_op.is_term = (req_item.item_mask == '0);
      new_op.slot    = slot_sel;
      new_op.mask    = req_item.item_mask;
      new_op.value   = req_item.item_value;
   end

   // Operation queue towards the back end.
   assign req_full = (count_ff == CNT_W'(OP_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign op_valid = (count_ff != '0);
   assign take_ok  = op_take && op_valid;
   assign op_data  = op_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !take_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && take_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries payload only.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         op_q_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule
`default_nettype wire

[design/mvlo_back.sv]
// Back end of the mask-value list orderer: slot store, emission sequencer
// and the response queue. Depends on mvlo_pkg.
`default_nettype none
module mvlo_back
   import mvlo_pkg::*;
#(
   parameter int SLOT_COUNT = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   input  wire op_type op_data,
   output logic        op_take,
   output logic        rsp_empty,
   input  wire logic   rsp_pop,
   output rsp_type     rsp_item
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_RUN  = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_COUNT-1:0]   filled_ff, filled_in;
   logic [MASK_W-1:0]       acc_ff, acc_in;
   logic [SLOT_COUNT-1:0]   pend_ff, pend_in;
   logic [MASK_W-1:0]       snap_ff, snap_in;
   logic [VALUE_W-1:0]      slot_mem [SLOT_COUNT];
   logic [VALUE_W-1:0]      rd_data_ff;
   logic                    fly_ff, fly_in;
   logic                    fly_last_ff, fly_last_in;
   logic                    fly_empty_ff, fly_empty_in;
   logic [MASK_W-1:0]       fly_mask_ff, fly_mask_in;
   rsp_type                 out_q_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]       owp_ff, owp_in;
   logic [OPTR_W-1:0]       orp_ff, orp_in;
   logic [OCNT_W-1:0]       ocnt_ff, ocnt_in;
   logic                    space;
   logic                    wr_en;
   logic                    rd_en;
   logic [SLOT_W-1:0]       wr_addr;
   logic [SLOT_W-1:0]       low_idx;
   logic [SLOT_COUNT-1:0]   low_hot;
   logic [SLOT_COUNT-1:0]   pend_rest;
   rsp_type                 push_entry;
   logic                    out_pop;

   // Room in the response queue, counting the read still in flight.
   assign space = ({1'b0, ocnt_ff} + (OCNT_W + 1)'(fly_ff)) < (OCNT_W + 1)'(OUT_DEPTH);

   // Lowest pending slot is the next one to emit.
   always_comb begin
      low_idx = '0;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            low_idx = SLOT_W'(k);
         end
      end
   end
   assign low_hot   = pend_ff & (~pend_ff + SLOT_COUNT'(1));
   assign pend_rest = pend_ff & ~low_hot;
   assign wr_addr   = op_data.slot[SLOT_W-1:0];

   // Sequencer: loads pairs, then walks the filled slots on a terminator.
   always_comb begin
      state_in     = state_ff;
      filled_in    = filled_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      snap_in      = snap_ff;
      fly_in       = 1'b0;
      fly_last_in  = fly_last_ff;
      fly_empty_in = fly_empty_ff;
      fly_mask_in  = fly_mask_ff;
      op_take      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (op_valid && !op_data.is_term) begin
               op_take   = 1'b1;
               wr_en     = 1'b1;
               filled_in = filled_ff | (SLOT_COUNT'(1) << wr_addr);
               acc_in    = acc_ff | op_data.mask;
            end else if (op_valid && space) begin
               op_take   = 1'b1;
               filled_in = '0;
               acc_in    = '0;
               if (filled_ff == '0) begin
                  fly_in       = 1'b1;
                  fly_last_in  = 1'b1;
                  fly_empty_in = 1'b1;
                  fly_mask_in  = acc_ff;
               end else begin
                  pend_in  = filled_ff;
                  snap_in  = acc_ff;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (space) begin
               rd_en        = 1'b1;
               fly_in       = 1'b1;
               fly_last_in  = (pend_rest == '0);
               fly_empty_in = 1'b0;
               fly_mask_in  = snap_ff;
               pend_in      = pend_rest;
               if (pend_rest == '0) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         filled_ff <= '0;
         acc_ff    <= '0;
         fly_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         acc_ff    <= acc_in;
         fly_ff    <= fly_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      snap_ff      <= snap_in;
      fly_last_ff  <= fly_last_in;
      fly_empty_ff <= fly_empty_in;
      fly_mask_ff  <= fly_mask_in;
   end

   // Slot store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= op_data.value;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[low_idx];
      end
   end

   // Response queue: filled from the read stage, drained by the consumer.
   always_comb begin
      push_entry.slot_value    = fly_empty_ff ? '0 : rd_data_ff;
      push_entry.combined_mask = fly_mask_ff;
      push_entry.is_last       = fly_last_ff;
      push_entry.is_empty      = fly_empty_ff;
   end

   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_item  = out_q_ff[orp_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      owp_in  = fly_ff ? owp_ff + 1'b1 : owp_ff;
      orp_in  = out_pop ? orp_ff + 1'b1 : orp_ff;
      ocnt_in = ocnt_ff;
      if (fly_ff && !out_pop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (!fly_ff && out_pop) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff  <= owp_in;
         orp_ff  <= orp_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fly_ff) begin
         out_q_ff[owp_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire
